>>> src/unix_epoch_to_calendar_date_assert.svh
// assertion macros for the calendar date block
`ifndef UNIX_EPOCH_TO_CALENDAR_DATE_ASSERT_SVH
`define UNIX_EPOCH_TO_CALENDAR_DATE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define UECD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar date check failed");

// next-cycle implication, sampled on clk, off while in reset
`define UECD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar date check failed");

`endif

>>> src/uecd_pkg.sv
package uecd_pkg;

    localparam int EPOCH_W  = 32;
    localparam int REM_W    = 17;
    localparam int QUO_W    = 16;
    localparam int DAYS_W   = 16;
    localparam int PC_W     = 4;
    localparam int SCALED_W = 25;
    localparam int RECIP_W  = 26;
    localparam int PROD_W   = SCALED_W + RECIP_W;

    localparam logic [REM_W-1:0]  DAY_SECS  = 17'd86400;
    localparam logic [REM_W-1:0]  HOUR_SECS = 17'd3600;
    localparam logic [REM_W-1:0]  MIN_SECS  = 17'd60;
    localparam logic [11:0]       BASE_YEAR = 12'd1970;
    localparam logic [11:0]       CENTURY_NOLEAP = 12'd2100;

    // reciprocals of the odd parts: 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15
    localparam logic [RECIP_W-1:0] DAY_RECIP  = 26'd50903317;
    localparam logic [RECIP_W-1:0] HOUR_RECIP = 26'd9321;
    localparam logic [RECIP_W-1:0] MIN_RECIP  = 26'd1093;
    localparam int                 DAY_SHIFT  = 35;
    localparam int                 HOUR_SHIFT = 21;
    localparam int                 MIN_SHIFT  = 14;

    localparam logic [3:0] LAST_MONTH = 4'd11;

    localparam logic [1:0] DIV_DAY  = 2'd0;
    localparam logic [1:0] DIV_HOUR = 2'd1;
    localparam logic [1:0] DIV_MIN  = 2'd2;

    localparam logic [3:0] OP_WAIT  = 4'd0;
    localparam logic [3:0] OP_QUO   = 4'd1;
    localparam logic [3:0] OP_REM   = 4'd2;
    localparam logic [3:0] OP_YEAR  = 4'd3;
    localparam logic [3:0] OP_MONTH = 4'd4;
    localparam logic [3:0] OP_EMIT  = 4'd5;

    localparam logic [PC_W-1:0] PC_WAIT     = 4'd0;
    localparam logic [PC_W-1:0] PC_DAY_QUO  = 4'd1;
    localparam logic [PC_W-1:0] PC_DAY_REM  = 4'd2;
    localparam logic [PC_W-1:0] PC_HOUR_QUO = 4'd3;
    localparam logic [PC_W-1:0] PC_HOUR_REM = 4'd4;
    localparam logic [PC_W-1:0] PC_MIN_QUO  = 4'd5;
    localparam logic [PC_W-1:0] PC_MIN_REM  = 4'd6;
    localparam logic [PC_W-1:0] PC_YEAR     = 4'd7;
    localparam logic [PC_W-1:0] PC_MONTH    = 4'd8;
    localparam logic [PC_W-1:0] PC_EMIT     = 4'd9;

    typedef struct packed {
        logic [3:0]      op;
        logic [1:0]      div_sel;
        logic [PC_W-1:0] next_pc;
    } ctrl_word_t;

    // control store: each step runs until its condition holds, then jumps
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            PC_WAIT:     w = '{OP_WAIT,  DIV_DAY,  PC_DAY_QUO};
            PC_DAY_QUO:  w = '{OP_QUO,   DIV_DAY,  PC_DAY_REM};
            PC_DAY_REM:  w = '{OP_REM,   DIV_DAY,  PC_HOUR_QUO};
            PC_HOUR_QUO: w = '{OP_QUO,   DIV_HOUR, PC_HOUR_REM};
            PC_HOUR_REM: w = '{OP_REM,   DIV_HOUR, PC_MIN_QUO};
            PC_MIN_QUO:  w = '{OP_QUO,   DIV_MIN,  PC_MIN_REM};
            PC_MIN_REM:  w = '{OP_REM,   DIV_MIN,  PC_YEAR};
            PC_YEAR:     w = '{OP_YEAR,  DIV_DAY,  PC_MONTH};
            PC_MONTH:    w = '{OP_MONTH, DIV_DAY,  PC_EMIT};
            PC_EMIT:     w = '{OP_EMIT,  DIV_DAY,  PC_WAIT};
            default:     w = '{OP_WAIT,  DIV_DAY,  PC_WAIT};
        endcase
        return w;
    endfunction

    // 2000 and 2100 are the only century years the block can reach
    function automatic logic is_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != CENTURY_NOLEAP);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> src/unix_epoch_to_calendar_date.sv
// Converts an unsigned 32-bit Unix time to Gregorian year, month, day and time of day
// (1970-01-01 up to 2106-02-07 06:28:15). One word is worked on at a time under a small
// microcoded sequencer: each split by 86400, 3600 and 60 takes two steps on one shared
// 25 by 26 bit multiplier, a quotient step by reciprocal multiplication and a remainder
// step, then one year length is subtracted per cycle and one month length per cycle.
// A year length is subtracted once for each whole year past 1970 (0 to 136 times) and
// a month length once for each month before the result month (0 to 11 times). The
// result sits in an output register, so the next word is taken while it waits; the
// sequencer only stalls at its last step if the previous result is still there and
// out_ready is low.
`include "unix_epoch_to_calendar_date_assert.svh"

module unix_epoch_to_calendar_date
    import uecd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [EPOCH_W-1:0]   epoch_seconds,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [11:0]          year,
    output logic [3:0]           month,
    output logic [4:0]           day,
    output logic [4:0]           hour,
    output logic [5:0]           minute,
    output logic [5:0]           second
);

    logic [PC_W-1:0]    pc_reg, pc_next;
    logic               out_valid_reg, out_valid_next;

    logic [EPOCH_W-1:0] num_reg, num_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [DAYS_W-1:0]  days_reg, days_next;
    logic [11:0]        cur_year_reg, cur_year_next;
    logic [3:0]         cur_month_reg, cur_month_next;
    logic [4:0]         hour_reg, hour_next;

    logic [11:0]        out_year_reg, out_year_next;
    logic [3:0]         out_month_reg, out_month_next;
    logic [4:0]         out_day_reg, out_day_next;
    logic [4:0]         out_hour_reg, out_hour_next;
    logic [5:0]         out_minute_reg, out_minute_next;
    logic [5:0]         out_second_reg, out_second_next;

    ctrl_word_t         ctrl;
    logic [REM_W-1:0]   divisor;
    logic [RECIP_W-1:0] recip;
    logic [SCALED_W-1:0] scaled;
    logic [REM_W-1:0]   rem_src;
    logic [SCALED_W-1:0] mul_a;
    logic [RECIP_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [QUO_W-1:0]   quo_val;
    logic [REM_W-1:0]   rem_val;
    logic               leap;
    logic [8:0]         year_len;
    logic [4:0]         mon_len;
    logic               out_free;

    assign ctrl = ucode(pc_reg);

    always_comb
    begin
        case (ctrl.div_sel)
            DIV_HOUR:
            begin
                divisor = HOUR_SECS;
                recip   = HOUR_RECIP;
                scaled  = {12'b0, rem_reg[REM_W-1:4]};
                rem_src = rem_reg;
            end
            DIV_MIN:
            begin
                divisor = MIN_SECS;
                recip   = MIN_RECIP;
                scaled  = {15'b0, rem_reg[11:2]};
                rem_src = rem_reg;
            end
            default:
            begin
                divisor = DAY_SECS;
                recip   = DAY_RECIP;
                scaled  = num_reg[EPOCH_W-1:EPOCH_W-SCALED_W];
                rem_src = num_reg[REM_W-1:0];
            end
        endcase
    end

    // quotient step multiplies by the reciprocal, remainder step by the divisor
    assign mul_a   = (ctrl.op == OP_REM) ? {9'b0, quo_reg} : scaled;
    assign mul_b   = (ctrl.op == OP_REM) ? {9'b0, divisor} : recip;
    assign mul_p   = {{RECIP_W{1'b0}}, mul_a} * {{SCALED_W{1'b0}}, mul_b};
    assign rem_val = rem_src - mul_p[REM_W-1:0];

    always_comb
    begin
        case (ctrl.div_sel)
            DIV_HOUR: quo_val = mul_p[HOUR_SHIFT +: QUO_W];
            DIV_MIN:  quo_val = mul_p[MIN_SHIFT +: QUO_W];
            default:  quo_val = mul_p[DAY_SHIFT +: QUO_W];
        endcase
    end

    assign leap     = is_leap(cur_year_reg);
    assign year_len = leap ? 9'd366 : 9'd365;
    assign mon_len  = month_len(cur_month_reg, leap);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        pc_next         = pc_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        num_next        = num_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        days_next       = days_reg;
        cur_year_next   = cur_year_reg;
        cur_month_next  = cur_month_reg;
        hour_next       = hour_reg;
        out_year_next   = out_year_reg;
        out_month_next  = out_month_reg;
        out_day_next    = out_day_reg;
        out_hour_next   = out_hour_reg;
        out_minute_next = out_minute_reg;
        out_second_next = out_second_reg;

        case (ctrl.op)
            OP_WAIT:
            begin
                if (in_valid)
                begin
                    num_next       = epoch_seconds;
                    cur_year_next  = BASE_YEAR;
                    cur_month_next = '0;
                    pc_next        = ctrl.next_pc;
                end
            end
            OP_QUO:
            begin
                quo_next = quo_val;
                pc_next  = ctrl.next_pc;
            end
            OP_REM:
            begin
                rem_next = rem_val;
                if (ctrl.div_sel == DIV_DAY)
                begin
                    days_next = quo_reg;
                end
                if (ctrl.div_sel == DIV_HOUR)
                begin
                    hour_next = quo_reg[4:0];
                end
                pc_next = ctrl.next_pc;
            end
            OP_YEAR:
            begin
                if (days_reg < {7'b0, year_len})
                begin
                    pc_next = ctrl.next_pc;
                end
                else
                begin
                    days_next     = days_reg - {7'b0, year_len};
                    cur_year_next = cur_year_reg + 12'd1;
                end
            end
            OP_MONTH:
            begin
                if ((cur_month_reg == LAST_MONTH) || (days_reg < {11'b0, mon_len}))
                begin
                    pc_next = ctrl.next_pc;
                end
                else
                begin
                    days_next      = days_reg - {11'b0, mon_len};
                    cur_month_next = cur_month_reg + 4'd1;
                end
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_year_next   = cur_year_reg;
                    out_month_next  = cur_month_reg + 4'd1;
                    out_day_next    = days_reg[4:0] + 5'd1;
                    out_hour_next   = hour_reg;
                    out_minute_next = quo_reg[5:0];
                    out_second_next = rem_reg[5:0];
                    out_valid_next  = 1'b1;
                    pc_next         = ctrl.next_pc;
                end
            end
            default:
            begin
                pc_next = PC_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg        <= num_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        days_reg       <= days_next;
        cur_year_reg   <= cur_year_next;
        cur_month_reg  <= cur_month_next;
        hour_reg       <= hour_next;
        out_year_reg   <= out_year_next;
        out_month_reg  <= out_month_next;
        out_day_reg    <= out_day_next;
        out_hour_reg   <= out_hour_next;
        out_minute_reg <= out_minute_next;
        out_second_reg <= out_second_next;
    end

    assign in_ready  = (pc_reg == PC_WAIT);
    assign out_valid = out_valid_reg;
    assign year      = out_year_reg;
    assign month     = out_month_reg;
    assign day       = out_day_reg;
    assign hour      = out_hour_reg;
    assign minute    = out_minute_reg;
    assign second    = out_second_reg;

    `UECD_ASSERT_NEXT(a_accept_starts_divide, in_valid && in_ready, pc_reg == PC_DAY_QUO)
    `UECD_ASSERT_NOW(a_rem_below_divisor, ctrl.op == OP_REM, rem_val < divisor)
    `UECD_ASSERT_NOW(a_day_in_range, pc_reg == PC_EMIT, days_reg < 16'd31)
    `UECD_ASSERT_NOW(a_month_in_range, pc_reg == PC_EMIT, cur_month_reg <= LAST_MONTH)
    `UECD_ASSERT_NEXT(a_emit_fills_output, (pc_reg == PC_EMIT) && out_free, out_valid_reg)

endmodule

>>> sim/tb_unix_epoch_to_calendar_date.sv
module tb_unix_epoch_to_calendar_date;
    import uecd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD        = 12;
    localparam int          RUN_LIMIT_CYCLES  = 1_600_000;
    localparam int          DRAIN_CYCLES      = 250;
    localparam int unsigned SECS_PER_DAY      = 86400;
    localparam int unsigned SECS_PER_HOUR     = 3600;
    localparam int unsigned SECS_PER_MIN      = 60;
    localparam int unsigned FIRST_YEAR        = 1970;
    localparam int unsigned LAST_FULL_DAY     = 49709;
    localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30,
                                                   31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } date_time_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [EPOCH_W-1:0]  epoch_seconds = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [11:0]         year;
    logic [3:0]          month;
    logic [4:0]          day;
    logic [4:0]          hour;
    logic [5:0]          minute;
    logic [5:0]          second;

    date_time_t          pending_dates [$];
    bit                  idling_on = 1'b1;
    int                  words_sent = 0;
    int                  dates_checked = 0;
    int                  date_errors = 0;

    unix_epoch_to_calendar_date u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .epoch_seconds (epoch_seconds),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour          (hour),
        .minute        (minute),
        .second        (second)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_PERIOD / 2);
        clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        return (m == 1 && leap_year(y)) ? 29 : DAYS_IN_MONTH[m];
    endfunction

    function automatic date_time_t epoch_to_date(input logic [EPOCH_W-1:0] t);
        date_time_t  d;
        int unsigned days;
        int unsigned secs;
        int unsigned yr;
        int unsigned mon;
        days = t / SECS_PER_DAY;
        secs = t % SECS_PER_DAY;
        yr   = FIRST_YEAR;
        mon  = 0;
        while (days >= (leap_year(yr) ? 366 : 365))
        begin
            days -= leap_year(yr) ? 366 : 365;
            yr++;
        end
        while (mon < 11 && days >= month_days(mon, yr))
        begin
            days -= month_days(mon, yr);
            mon++;
        end
        d.year   = 12'(yr);
        d.month  = 4'(mon + 1);
        d.day    = 5'(days + 1);
        d.hour   = 5'(secs / SECS_PER_HOUR);
        d.minute = 6'((secs % SECS_PER_HOUR) / SECS_PER_MIN);
        d.second = 6'(secs % SECS_PER_MIN);
        return d;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [EPOCH_W-1:0] t);
        if (idling_on && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid      <= 1'b1;
        epoch_seconds <= t;
        do
            @(posedge clk);
        while (!in_ready);
        pending_dates.push_back(epoch_to_date(t));
        words_sent++;
        @(negedge clk);
    endtask

    function automatic logic [EPOCH_W-1:0] day_edge_epoch();
        logic [EPOCH_W-1:0] base;
        base = $urandom_range(0, LAST_FULL_DAY) * SECS_PER_DAY;
        case ($urandom_range(0, 3))
            0:       return base;
            1:       return base + SECS_PER_DAY - 1;
            2:       return base + $urandom_range(0, 23) * SECS_PER_HOUR + SECS_PER_HOUR - 1;
            default: return base + $urandom_range(0, SECS_PER_DAY - 1);
        endcase
    endfunction

    // month ends, leap days, year ends, century years and the 32-bit extremes
    task automatic test_directed_edges();
        logic [EPOCH_W-1:0] edge_words [26] = '{
            32'd0,          32'hFFFF_FFFF,  32'h5555_5555,  32'hAAAA_AAAA,
            32'd59,         32'd3599,       32'd3600,       32'd86399,
            32'd2678399,    32'd2678400,    32'd31535999,   32'd31536000,
            32'd68255999,   32'd68256000,   32'd94694399,   32'd946684799,
            32'd946684800,  32'd951782400,  32'd951868799,  32'd978307199,
            32'd2147483647, 32'd2147483648, 32'd4107542399, 32'd4107542400,
            32'd4133980799, 32'd4294944000
        };
        foreach (edge_words[i])
            send_word(edge_words[i]);
    endtask

    task automatic test_random_epochs(input int count);
        repeat (count)
            send_word($urandom);
    endtask

    task automatic test_day_boundaries(input int count);
        repeat (count)
            send_word(day_edge_epoch());
    endtask

    task automatic test_back_to_back(input int count);
        idling_on = 1'b0;
        repeat (count)
            send_word($urandom_range(0, 1) ? $urandom : day_edge_epoch());
    endtask

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 15) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        date_time_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dates.size() == 0)
            begin
                $error("date word with nothing pending");
                date_errors++;
            end
            else
            begin
                want = pending_dates.pop_front();
                dates_checked++;
                if (year !== want.year)
                begin
                    $error("year: expected %0d, got %0d", want.year, year);
                    date_errors++;
                end
                if (month !== want.month)
                begin
                    $error("month: expected %0d, got %0d", want.month, month);
                    date_errors++;
                end
                if (day !== want.day)
                begin
                    $error("day: expected %0d, got %0d", want.day, day);
                    date_errors++;
                end
                if (hour !== want.hour)
                begin
                    $error("hour: expected %0d, got %0d", want.hour, hour);
                    date_errors++;
                end
                if (minute !== want.minute)
                begin
                    $error("minute: expected %0d, got %0d", want.minute, minute);
                    date_errors++;
                end
                if (second !== want.second)
                begin
                    $error("second: expected %0d, got %0d", want.second, second);
                    date_errors++;
                end
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d dates still pending", pending_dates.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_edges();
        test_random_epochs(580);
        test_day_boundaries(500);
        test_back_to_back(300);

        in_valid <= 1'b0;
        wait (pending_dates.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d epoch words sent, %0d dates checked", words_sent, dates_checked);
        $display("covered month and year ends, leap days, 2100, full 32-bit range, stalls");
        if (date_errors == 0 && pending_dates.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
